/* rtl/core/query_string_percent_decoder_assert.svh */
// ---------------------------------------------------------------------------
// query_string_percent_decoder_assert.svh
// Assertion macros for the query string decoder. Empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef QUERY_STRING_PERCENT_DECODER_ASSERT_SVH
`define QUERY_STRING_PERCENT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define QSPD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QSPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define QSPD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)

`define QSPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/core/qspd_pkg.sv */
// ---------------------------------------------------------------------------
// qspd_pkg
// Types, character codes and escape conversion for the query string decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package qspd_pkg;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,  // no escape open
    ESC_PCT  = 2'd1,  // '%' seen
    ESC_HELD = 2'd2   // first escape char held
  } esc_t;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam int QUEUE_DEPTH = 3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       key_bad;
    logic       value_bad;
    logic       no_equals;
    logic       query_done;
    logic       run_last;
  } res_t;

  // {valid, digit}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // two-char base-16 conversion with whitespace, sign and stop rules
  function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic       is_ws;
    logic [7:0] r;
    ha    = hex_val(a);
    hb    = hex_val(b);
    is_ws = (a == CHAR_SPACE) || (a == CHAR_TAB) || (a >= CHAR_LF && a <= CHAR_CR);
    r     = 8'd0;
    if (a == CHAR_NUL) begin
      r = 8'd0;
    end else if (is_ws || a == CHAR_PLUS) begin
      r = hb[4] ? {4'h0, hb[3:0]} : 8'd0;
    end else if (a == CHAR_MINUS) begin
      r = hb[4] ? 8'(8'd0 - {4'h0, hb[3:0]}) : 8'd0;
    end else if (ha[4]) begin
      r = hb[4] ? {ha[3:0], hb[3:0]} : {4'h0, ha[3:0]};
    end
    return r;
  endfunction

  // end-of-pair word from the pair state
  function automatic res_t end_word(input logic in_value, input logic esc_open,
                                    input logic key_err);
    res_t r;
    r.kind       = KIND_END;
    r.data       = 8'd0;
    r.key_bad    = in_value ? key_err : esc_open;
    r.value_bad  = esc_open;
    r.no_equals  = !in_value;
    r.query_done = 1'b0;
    r.run_last   = 1'b0;
    return r;
  endfunction

  function automatic res_t data_word(input kind_t k, input logic [7:0] d);
    res_t r;
    r.kind       = k;
    r.data       = d;
    r.key_bad    = 1'b0;
    r.value_bad  = 1'b0;
    r.no_equals  = 1'b0;
    r.query_done = 1'b0;
    r.run_last   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/query_string_percent_decoder.sv */
// ---------------------------------------------------------------------------
// query_string_percent_decoder
// Splits a query string into key/value pairs and percent-decodes them.
// ---------------------------------------------------------------------------
// Takes one raw byte per cycle on the slave stream (tlast marks the final
// byte of a query) and emits decoded words on the master stream: key bytes,
// value bytes and one end-of-pair word per pair carrying key_bad, value_bad
// and no_equals. '&' ends a pair, the first '=' in a pair ends the key, and
// '%' opens a two-char escape converted with C base-16 rules (whitespace,
// sign, stop at first non-hex char). A leading '&' is skipped; a trailing '&'
// adds an empty pair. tlast on the master side marks the last word caused by
// one input byte. Throughput: one byte per cycle while s_tready is high; the
// output words are registered. A byte causes zero, one or two words; the
// decode and state update run in one combinational pass into a three-word
// output queue, and the master port drains one word per cycle while m_tready
// is high, so a stream with many two-word bytes (a final data byte, a final
// '&') is paced by that port. The slave side stays ready while the queue
// holds at most one word, so once two words wait on a stalled master side
// intake stops until a word drains. No clearing pass.
`default_nettype none

`include "query_string_percent_decoder_assert.svh"

module query_string_percent_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // final_byte
  // output stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,   // [7:0] data_byte, [8] key_bad,
                                      // [9] value_bad, [10] no_equals,
                                      // [11] query_done, [15:12] zero
  output      logic [1:0]  m_tuser,   // [1:0] kind
  output      logic        m_tlast    // run_last
);

  // pair state
  logic                in_value_part, in_value_part_next;
  logic                at_query_start, at_query_start_next;
  qspd_pkg::esc_t      escape_count, escape_count_next;
  logic [7:0]          held_hex_char, held_hex_char_next;
  logic                key_error, key_error_next;

  // output queue, head at entry 0
  qspd_pkg::res_t      q [qspd_pkg::QUEUE_DEPTH];
  qspd_pkg::res_t      q_next [qspd_pkg::QUEUE_DEPTH];
  logic [1:0]          q_cnt, q_cnt_next;

  logic                s_acc;
  logic                pop;
  logic [1:0]          base;
  logic [1:0]          n_res;
  qspd_pkg::res_t      res0, res1;

  // step results before run_last / query_done marking
  logic [1:0]          n_raw;
  qspd_pkg::res_t      raw0, raw1;

  // state after the byte, before the final-byte end of pair
  logic                ivp_upd;
  qspd_pkg::esc_t      esc_upd;
  logic [7:0]          held_upd;
  logic                kerr_upd;
  qspd_pkg::kind_t     data_kind;

  assign s_tready = (q_cnt <= 2'd1);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = (q_cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;

  assign m_tuser = q[0].kind;
  assign m_tdata = {4'h0, q[0].query_done, q[0].no_equals, q[0].value_bad,
                    q[0].key_bad, q[0].data};
  assign m_tlast = q[0].run_last;

  // one byte: classify, produce up to two words, update the pair state
  always_comb begin
    n_raw     = 2'd0;
    raw0      = qspd_pkg::end_word(1'b0, 1'b0, 1'b0);
    raw1      = qspd_pkg::end_word(1'b0, 1'b0, 1'b0);
    ivp_upd   = in_value_part;
    esc_upd   = escape_count;
    held_upd  = held_hex_char;
    kerr_upd  = key_error;
    data_kind = in_value_part ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_KEY;

    if (at_query_start && s_tdata == qspd_pkg::CHAR_AMP) begin
      // leading '&' skipped; a lone final '&' still closes one empty pair
      if (s_tlast) begin
        n_raw = 2'd1;
      end
    end else if (s_tdata == qspd_pkg::CHAR_AMP) begin
      raw0     = qspd_pkg::end_word(in_value_part, escape_count != qspd_pkg::ESC_NONE,
                                    key_error);
      n_raw    = s_tlast ? 2'd2 : 2'd1;   // trailing '&' adds an empty pair
      ivp_upd  = 1'b0;
      esc_upd  = qspd_pkg::ESC_NONE;
      held_upd = 8'd0;
      kerr_upd = 1'b0;
    end else begin
      if (!in_value_part && s_tdata == qspd_pkg::CHAR_EQ) begin
        kerr_upd = (escape_count != qspd_pkg::ESC_NONE);
        ivp_upd  = 1'b1;
        esc_upd  = qspd_pkg::ESC_NONE;
        held_upd = 8'd0;
      end else if (escape_count == qspd_pkg::ESC_PCT) begin
        held_upd = s_tdata;
        esc_upd  = qspd_pkg::ESC_HELD;
      end else if (escape_count == qspd_pkg::ESC_HELD) begin
        raw0     = qspd_pkg::data_word(data_kind,
                                       qspd_pkg::decode_pair(held_hex_char, s_tdata));
        n_raw    = 2'd1;
        esc_upd  = qspd_pkg::ESC_NONE;
        held_upd = 8'd0;
      end else if (s_tdata == qspd_pkg::CHAR_PCT) begin
        esc_upd = qspd_pkg::ESC_PCT;
      end else begin
        raw0  = qspd_pkg::data_word(data_kind, s_tdata);
        n_raw = 2'd1;
      end

      if (s_tlast) begin
        if (n_raw == 2'd0) begin
          raw0  = qspd_pkg::end_word(ivp_upd, esc_upd != qspd_pkg::ESC_NONE, kerr_upd);
          n_raw = 2'd1;
        end else begin
          raw1  = qspd_pkg::end_word(ivp_upd, esc_upd != qspd_pkg::ESC_NONE, kerr_upd);
          n_raw = 2'd2;
        end
      end
    end

    // tag the last word of this byte
    res0  = raw0;
    res1  = raw1;
    n_res = n_raw;
    if (n_raw == 2'd1) begin
      res0.run_last   = 1'b1;
      res0.query_done = s_tlast;
    end else if (n_raw == 2'd2) begin
      res1.run_last   = 1'b1;
      res1.query_done = s_tlast;
    end

    // next pair state
    in_value_part_next  = in_value_part;
    at_query_start_next = at_query_start;
    escape_count_next   = escape_count;
    held_hex_char_next  = held_hex_char;
    key_error_next      = key_error;
    if (s_acc) begin
      if (s_tlast) begin
        in_value_part_next  = 1'b0;
        at_query_start_next = 1'b1;
        escape_count_next   = qspd_pkg::ESC_NONE;
        held_hex_char_next  = 8'd0;
        key_error_next      = 1'b0;
      end else begin
        in_value_part_next  = ivp_upd;
        at_query_start_next = 1'b0;
        escape_count_next   = esc_upd;
        held_hex_char_next  = held_upd;
        key_error_next      = kerr_upd;
      end
    end
  end

  // queue: shift out on pop, append at the first free slot
  always_comb begin
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = pop ? q[2] : q[1];
    q_next[2] = q[2];
    base      = q_cnt - {1'b0, pop};
    q_cnt_next = base;
    if (s_acc) begin
      if (n_res != 2'd0) begin
        q_next[base] = res0;
      end
      if (n_res == 2'd2) begin
        q_next[2'(base + 2'd1)] = res1;
      end
      q_cnt_next = 2'(base + n_res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value_part  <= 1'b0;
      at_query_start <= 1'b1;
      escape_count   <= qspd_pkg::ESC_NONE;
      held_hex_char  <= 8'd0;
      key_error      <= 1'b0;
      q_cnt          <= 2'd0;
    end else begin
      in_value_part  <= in_value_part_next;
      at_query_start <= at_query_start_next;
      escape_count   <= escape_count_next;
      held_hex_char  <= held_hex_char_next;
      key_error      <= key_error_next;
      q_cnt          <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  // checks
  `QSPD_ASSERT_NEXT(a_final_restarts, clk, rst, s_acc && s_tlast,
    at_query_start && !in_value_part && escape_count == qspd_pkg::ESC_NONE,
    "final byte did not reset pair state")
  `QSPD_ASSERT_IMPL(a_esc_mid_query, clk, rst, escape_count != qspd_pkg::ESC_NONE,
    !at_query_start, "escape open at query start")
  `QSPD_ASSERT_IMPL(a_end_no_data, clk, rst, m_tvalid && m_tuser == qspd_pkg::KIND_END,
    m_tdata[7:0] == 8'd0, "end-of-pair word carries data")
  `QSPD_ASSERT_IMPL(a_data_no_flags, clk, rst, m_tvalid && m_tuser != qspd_pkg::KIND_END,
    m_tdata[10:8] == 3'd0, "data word carries pair flags")

endmodule

`default_nettype wire

/* tb/query_string_percent_decoder_checker.sv */
// ---------------------------------------------------------------------------
// query_string_percent_decoder_checker
// Watches both streams of the query string decoder. It predicts the decoded
// words for every accepted byte and compares each output word in order.
// ---------------------------------------------------------------------------
`default_nettype none

module query_string_percent_decoder_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        m_tlast,
  output int               errors,
  output int               pending,
  output int               words_checked,
  output int               pairs_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  // predicted decoder state
  logic           in_value;
  logic           at_start;
  qspd_pkg::esc_t esc;
  logic [7:0]     held;
  logic           key_err;
  logic           val_err;

  qspd_pkg::res_t expected_words[$];
  int   err_cnt;
  int   word_cnt;
  int   pair_cnt;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  // two-char base-16 read: blanks and sign on the first char, stop at non-hex
  function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
    int ha;
    int hb;
    ha = hex_nibble(a);
    hb = hex_nibble(b);
    if (a == qspd_pkg::CHAR_NUL) return 8'h00;
    if (a == qspd_pkg::CHAR_SPACE || a == qspd_pkg::CHAR_TAB ||
        a == qspd_pkg::CHAR_LF || a == CHAR_VT || a == CHAR_FF ||
        a == qspd_pkg::CHAR_CR || a == qspd_pkg::CHAR_PLUS)
      return (hb < 0) ? 8'h00 : 8'(hb);
    if (a == qspd_pkg::CHAR_MINUS) return (hb < 0) ? 8'h00 : 8'(256 - hb);
    if (ha >= 0) return (hb < 0) ? 8'(ha) : 8'(ha * 16 + hb);
    return 8'h00;
  endfunction

  function automatic void clear_pair_state();
    in_value = 1'b0;
    esc      = qspd_pkg::ESC_NONE;
    held     = 8'h00;
    key_err  = 1'b0;
    val_err  = 1'b0;
  endfunction

  function automatic void push_data(input qspd_pkg::kind_t k, input logic [7:0] d);
    qspd_pkg::res_t w;
    w            = '0;
    w.kind       = k;
    w.data       = d;
    expected_words.push_back(w);
  endfunction

  // end-of-pair word; an open escape sets value_bad, and in the key part key_bad too
  function automatic void close_pair();
    qspd_pkg::res_t w;
    w = '0;
    if (in_value) begin
      val_err     = (esc != qspd_pkg::ESC_NONE);
      w.no_equals = 1'b0;
    end else begin
      key_err     = (esc != qspd_pkg::ESC_NONE);
      val_err     = key_err;
      w.no_equals = 1'b1;
    end
    w.kind      = qspd_pkg::KIND_END;
    w.key_bad   = key_err;
    w.value_bad = val_err;
    expected_words.push_back(w);
    clear_pair_state();
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic fin);
    int              first;
    qspd_pkg::kind_t k;
    qspd_pkg::res_t  w;
    first = expected_words.size();
    if (at_start && c == qspd_pkg::CHAR_AMP) begin
      // leading '&' is dropped
      at_start = 1'b0;
      if (fin) close_pair();
    end else begin
      at_start = 1'b0;
      if (c == qspd_pkg::CHAR_AMP) begin
        close_pair();
        if (fin) close_pair();
      end else begin
        k = in_value ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_KEY;
        if (!in_value && c == qspd_pkg::CHAR_EQ) begin
          key_err  = (esc != qspd_pkg::ESC_NONE);
          in_value = 1'b1;
          esc      = qspd_pkg::ESC_NONE;
          held     = 8'h00;
        end else if (esc == qspd_pkg::ESC_PCT) begin
          held = c;
          esc  = qspd_pkg::ESC_HELD;
        end else if (esc == qspd_pkg::ESC_HELD) begin
          push_data(k, escape_value(held, c));
          esc  = qspd_pkg::ESC_NONE;
          held = 8'h00;
        end else if (c == qspd_pkg::CHAR_PCT) begin
          esc = qspd_pkg::ESC_PCT;
        end else begin
          push_data(k, c);
        end
        if (fin) close_pair();
      end
    end
    if (fin) begin
      clear_pair_state();
      at_start = 1'b1;
    end
    if (expected_words.size() > first) begin
      w          = expected_words.pop_back();
      w.run_last = 1'b1;
      if (fin) w.query_done = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  function automatic void check_word();
    qspd_pkg::res_t want;
    word_cnt++;
    if (expected_words.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("[%0t] unexpected word: kind=%0d data=%02h flags=%04b last=%0b",
                 $realtime, m_tuser, m_tdata[7:0], m_tdata[11:8], m_tlast);
      return;
    end
    want = expected_words.pop_front();
    if (want.kind == qspd_pkg::KIND_END) pair_cnt++;
    if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
        m_tdata[8] !== want.key_bad || m_tdata[9] !== want.value_bad ||
        m_tdata[10] !== want.no_equals || m_tdata[11] !== want.query_done ||
        m_tdata[15:12] !== 4'h0 || m_tlast !== want.run_last) begin
      err_cnt++;
      if (err_cnt <= 10) begin
        $display("[%0t] word %0d mismatch (flags = done,no_eq,val_bad,key_bad)",
                 $realtime, word_cnt);
        $display("  expected kind=%0d data=%02h flags=%b%b%b%b pad=0 last=%0b",
                 want.kind, want.data, want.query_done, want.no_equals,
                 want.value_bad, want.key_bad, want.run_last);
        $display("  actual   kind=%0d data=%02h flags=%04b pad=%0h last=%0b",
                 m_tuser, m_tdata[7:0], m_tdata[11:8], m_tdata[15:12], m_tlast);
      end
    end
  endfunction

  // Sample at the edge; byte intake goes first so a word output in the same
  // cycle as its byte would still find its prediction.
  always @(posedge clk) begin
    if (rst) begin
      clear_pair_state();
      at_start = 1'b1;
      expected_words.delete();
      err_cnt  = 0;
      word_cnt = 0;
      pair_cnt = 0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_word();
    end
    errors        <= err_cnt;
    pending       <= expected_words.size();
    words_checked <= word_cnt;
    pairs_checked <= pair_cnt;
  end

endmodule

`default_nettype wire

/* tb/tb_query_string_percent_decoder.sv */
// ---------------------------------------------------------------------------
// tb_query_string_percent_decoder
// Drives query strings into the percent decoder and gives the verdict.
// A short hand-written set of queries hits the escape and separator corner
// cases; random queries follow under three back-pressure mixes. The checker
// beside the block predicts and compares every output word.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_query_string_percent_decoder;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_tlast  = 1'b0;   // final_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [7:0] data_byte, [8] key_bad, [9] value_bad,
                                  // [10] no_equals, [11] query_done, [15:12] zero
  logic [1:0]  m_tuser;           // [1:0] kind
  logic        m_tlast;           // run_last

  int errors;
  int pending;
  int words_checked;
  int pairs_checked;

  // idle odds in percent, per side
  int send_idle = 30;
  int recv_idle = 47;

  int         bytes_sent = 0;
  int         queries    = 0;
  logic [7:0] query_bytes[$];

  always #5 clk = ~clk;

  query_string_percent_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  query_string_percent_decoder_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .errors        (errors),
    .pending       (pending),
    .words_checked (words_checked),
    .pairs_checked (pairs_checked)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Present one byte and hold it until taken. tvalid stays up between
  // back-to-back words and only drops for an idle cycle.
  task automatic push_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_query();
    foreach (query_bytes[i]) push_byte(query_bytes[i], i == query_bytes.size() - 1);
    queries++;
  endtask

  // ordinary data byte: never a separator or escape opener
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h30, 8'h7A));
    end while (c == qspd_pkg::CHAR_PCT || c == qspd_pkg::CHAR_AMP ||
               c == qspd_pkg::CHAR_EQ);
    return c;
  endfunction

  // escape char: mostly hex, some blanks/signs/NUL, some anything
  function automatic logic [7:0] escape_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      r = $urandom_range(0, 21);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 16) return 8'(8'h61 + r - 10);
      return 8'(8'h41 + r - 16);
    end
    if (r < 8) begin
      case ($urandom_range(0, 8))
        0:       return qspd_pkg::CHAR_NUL;
        1:       return qspd_pkg::CHAR_SPACE;
        2:       return qspd_pkg::CHAR_TAB;
        3:       return qspd_pkg::CHAR_LF;
        4:       return 8'h0B;  // VT
        5:       return 8'h0C;  // FF
        6:       return qspd_pkg::CHAR_CR;
        7:       return qspd_pkg::CHAR_PLUS;
        default: return qspd_pkg::CHAR_MINUS;
      endcase
    end
    return 8'($urandom);
  endfunction

  // key or value text, sometimes cut off inside an escape
  function automatic void add_part(input bit value_side);
    int n;
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: query_bytes.push_back(plain_byte());
        9:             query_bytes.push_back(value_side ? qspd_pkg::CHAR_EQ : plain_byte());
        default: begin
          query_bytes.push_back(qspd_pkg::CHAR_PCT);
          query_bytes.push_back(escape_byte());
          query_bytes.push_back(escape_byte());
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      query_bytes.push_back(qspd_pkg::CHAR_PCT);
      if ($urandom_range(0, 1) == 1) query_bytes.push_back(escape_byte());
    end
  endfunction

  // Mostly well-formed key=value lists; one in ten is byte noise rich in
  // separators.
  function automatic void build_query();
    int n;
    query_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0:       query_bytes.push_back(qspd_pkg::CHAR_PCT);
          1:       query_bytes.push_back(qspd_pkg::CHAR_AMP);
          2:       query_bytes.push_back(qspd_pkg::CHAR_EQ);
          default: query_bytes.push_back(8'($urandom));
        endcase
      end
      return;
    end
    if ($urandom_range(0, 7) == 0) query_bytes.push_back(qspd_pkg::CHAR_AMP);
    n = $urandom_range(1, 4);
    for (int p = 0; p < n; p++) begin
      if (p > 0) query_bytes.push_back(qspd_pkg::CHAR_AMP);
      add_part(1'b0);
      if ($urandom_range(0, 4) != 0) begin
        query_bytes.push_back(qspd_pkg::CHAR_EQ);
        add_part(1'b1);
      end
    end
    if ($urandom_range(0, 7) == 0) query_bytes.push_back(qspd_pkg::CHAR_AMP);
  endfunction

  initial begin
    int stop_at;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone '&' as a whole query: one empty pair
    query_bytes = {qspd_pkg::CHAR_AMP};
    send_query();
    // skipped leading '&', hex pair, '=' inside a key escape, minus, NUL,
    // plus and blank first chars, then a final '&' adding an empty pair
    query_bytes = {qspd_pkg::CHAR_AMP, qspd_pkg::CHAR_PCT, "4", "1",
                   qspd_pkg::CHAR_PCT, "5", qspd_pkg::CHAR_EQ,
                   qspd_pkg::CHAR_PCT, qspd_pkg::CHAR_MINUS, "F",
                   qspd_pkg::CHAR_PCT, qspd_pkg::CHAR_NUL, "x",
                   qspd_pkg::CHAR_PCT, qspd_pkg::CHAR_PLUS, "7",
                   qspd_pkg::CHAR_PCT, qspd_pkg::CHAR_SPACE, "z", qspd_pkg::CHAR_AMP};
    send_query();
    // top byte, non-hex first char, '&' cutting an escape, final lone '%'
    query_bytes = {8'hFF, qspd_pkg::CHAR_PCT, "q", "9", qspd_pkg::CHAR_PCT, "A",
                   qspd_pkg::CHAR_AMP, qspd_pkg::CHAR_PCT};
    send_query();

    // random queries under three idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle <= 30;
          recv_idle <= 47;
        end
        1: begin
          send_idle <= 47;
          recv_idle <= 30;
        end
        default: begin
          send_idle <= 0;
          recv_idle <= 0;
        end
      endcase
      stop_at = bytes_sent + 300;
      while (bytes_sent < stop_at) begin
        build_query();
        send_query();
      end
    end
    s_tvalid <= 1'b0;

    // drain, then allow for the output latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d bytes in %0d query strings under three back-pressure mixes;",
             bytes_sent, queries);
    $display("%0d output words compared, %0d of them pair ends, %0d mismatches.",
             words_checked, pairs_checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
